/* design/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg
// shared codes, character constants and structures of the serial led
// command decoder
// ----------------------------------------------------------------------------
package slcd_pkg;

   // parse modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_SETTING = 2'd1;
   localparam logic [1:0] MODE_TEXT    = 2'd2;

   // result commands
   localparam logic [2:0] CMD_BRIGHTNESS = 3'd0;
   localparam logic [2:0] CMD_COLOR      = 3'd1;
   localparam logic [2:0] CMD_INCREMENT  = 3'd2;
   localparam logic [2:0] CMD_SCROLL     = 3'd3;
   localparam logic [2:0] CMD_TEST       = 3'd4;
   localparam logic [2:0] CMD_APPEND     = 3'd5;

   // colour channels
   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   // received characters of interest
   localparam logic [7:0] CHAR_SETTING = 8'h11;
   localparam logic [7:0] CHAR_TEXT    = 8'h12;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_K       = 8'h6B;
   localparam logic [7:0] CHAR_R       = 8'h72;
   localparam logic [7:0] CHAR_G       = 8'h67;
   localparam logic [7:0] CHAR_B       = 8'h62;
   localparam logic [7:0] CHAR_I       = 8'h69;
   localparam logic [7:0] CHAR_S       = 8'h73;
   localparam logic [7:0] CHAR_T       = 8'h74;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] PRINT_LOW    = 8'h20;
   localparam logic [7:0] PRINT_HIGH   = 8'h7E;

   // setting line characters kept
   localparam int SETTING_MAX = 15;

   typedef struct packed {
      logic [1:0]  mode;
      logic        line_k;
      logic        digits_ended;
      logic [31:0] accum;
      logic [31:0] brightness;
      logic        increment_on;
      logic        scroll_on;
      logic        test_on;
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  command;
      logic [31:0] brightness_value;
      logic [1:0]  color_channel;
      logic [7:0]  color_level;
      logic        flag_value;
      logic [6:0]  text_char;
      logic [4:0]  text_length;
   } result_type;

endpackage

/* design/serial_led_command_decoder.sv */
// ----------------------------------------------------------------------------
// serial_led_command_decoder
// parses received serial characters into led commands: colour, brightness,
// flag toggles and text appends
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  req_rx_char
//  rsp_      out        rsp_valid / rsp_stall  rsp_command, rsp_brightness_value,
//                                              rsp_color_channel, rsp_color_level,
//                                              rsp_flag_value, rsp_text_char,
//                                              rsp_text_length
//
//  one beat per cycle in and out while rsp is not stalled; a character waits
//  in the input register, is decoded and updates the parser state as it
//  leaves, and its result (if any) appears the cycle after
//  a req beat passes the input register and then the result register on its
//  way to rsp; the parser state update is the loop that sets the rate
//  reset is synchronous and clears the parser to idle with brightness 0
//  a stalled rsp beat that is waiting stops the decode stage, and req_stall
//  follows while the input register is full
//
module serial_led_command_decoder #(
   parameter int TEXT_CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [31:0] rsp_brightness_value,
   output logic [1:0]  rsp_color_channel,
   output logic [7:0]  rsp_color_level,
   output logic        rsp_flag_value,
   output logic [6:0]  rsp_text_char,
   output logic [4:0]  rsp_text_length
);

   // count must hold the text capacity, the setting limit and a 5-bit length
   localparam int CNT_W = ($clog2(TEXT_CAPACITY + 1) > 5) ? $clog2(TEXT_CAPACITY + 1) : 5;

   // input register
   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           rx_ff;

   // parser state
   slcd_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // result register
   logic                 out_vld_ff, out_vld_in;
   slcd_pkg::result_type res_ff;
   slcd_pkg::result_type res_in;

   logic                 out_free;
   logic                 fire;
   logic                 accept;

   // decode fires when the input register is full and the result slot is free or being emptied
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !fire;
   assign accept    = req_valid && !req_stall;

   slcd_decode #(
      .TEXT_CAPACITY (TEXT_CAPACITY),
      .CNT_W         (CNT_W)
   ) u_decode (
      .rx_char    (rx_ff),
      .state      (state_ff),
      .count      (count_ff),
      .state_next (state_in),
      .count_next (count_in),
      .result     (res_in)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (fire) begin
         out_vld_in = res_in.valid;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '{mode: slcd_pkg::MODE_IDLE, default: '0};
         count_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (fire) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rx_ff <= req_rx_char;
      end
      if (fire && res_in.valid) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_command          = res_ff.command;
   assign rsp_brightness_value = res_ff.brightness_value;
   assign rsp_color_channel    = res_ff.color_channel;
   assign rsp_color_level      = res_ff.color_level;
   assign rsp_flag_value       = res_ff.flag_value;
   assign rsp_text_char        = res_ff.text_char;
   assign rsp_text_length      = res_ff.text_length;

   // reset leaves the parser idle at zero brightness
   assert property (@(posedge clock)
      reset |=> (state_ff.mode == slcd_pkg::MODE_IDLE) && (state_ff.brightness == 32'd0))
      else $error("parser not cleared by reset");

   // a waiting result always carries the brightness the parser holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_brightness_value == state_ff.brightness))
      else $error("result brightness differs from parser brightness");

   // an append result reports the current text length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_command == slcd_pkg::CMD_APPEND))
         |-> (rsp_text_length == count_ff[4:0]))
      else $error("append length differs from text count");

   // a decoded result is presented the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (fire && res_in.valid) |=> rsp_valid)
      else $error("decoded result lost");

endmodule

/* design/slcd_decode.sv */
// ----------------------------------------------------------------------------
// slcd_decode
// next state and result of the command parser for one received character
// ----------------------------------------------------------------------------
module slcd_decode #(
   parameter int TEXT_CAPACITY = 16,
   parameter int CNT_W         = 5
) (
   input  logic [7:0]               rx_char,
   input  slcd_pkg::state_type      state,
   input  logic [CNT_W-1:0]         count,
   output slcd_pkg::state_type      state_next,
   output logic [CNT_W-1:0]         count_next,
   output slcd_pkg::result_type     result
);

   logic [35:0]      scaled;
   logic [CNT_W-1:0] count_inc;
   logic             is_digit;
   logic             is_print;

   // accum * 10 + digit as two shifts and two adds
   assign scaled    = {1'b0, state.accum, 3'b000} + {3'b000, state.accum, 1'b0}
                    + {32'd0, rx_char[3:0]};
   assign count_inc = count + CNT_W'(1);
   assign is_digit  = (rx_char >= slcd_pkg::CHAR_ZERO) && (rx_char <= slcd_pkg::CHAR_NINE);
   assign is_print  = (rx_char >= slcd_pkg::PRINT_LOW) && (rx_char <= slcd_pkg::PRINT_HIGH);

   always_comb begin
      state_next = state;
      count_next = count;
      result     = '0;
      result.brightness_value = state.brightness;

      unique case (state.mode)
         slcd_pkg::MODE_SETTING: begin
            unique case (rx_char) inside
               slcd_pkg::CHAR_LF, slcd_pkg::CHAR_CR: begin
                  state_next.mode = slcd_pkg::MODE_IDLE;
                  if (state.line_k) begin
                     state_next.brightness   = state.accum;
                     result.valid            = 1'b1;
                     result.command          = slcd_pkg::CMD_BRIGHTNESS;
                     result.brightness_value = state.accum;
                  end
               end
               slcd_pkg::CHAR_R, slcd_pkg::CHAR_G, slcd_pkg::CHAR_B: begin
                  state_next.mode    = slcd_pkg::MODE_IDLE;
                  result.valid       = 1'b1;
                  result.command     = slcd_pkg::CMD_COLOR;
                  result.color_level = state.brightness[7:0];
                  if (rx_char == slcd_pkg::CHAR_R) begin
                     result.color_channel = slcd_pkg::CHAN_RED;
                  end else if (rx_char == slcd_pkg::CHAR_G) begin
                     result.color_channel = slcd_pkg::CHAN_GREEN;
                  end else begin
                     result.color_channel = slcd_pkg::CHAN_BLUE;
                  end
               end
               slcd_pkg::CHAR_I: begin
                  state_next.mode         = slcd_pkg::MODE_IDLE;
                  state_next.increment_on = ~state.increment_on;
                  result.valid            = 1'b1;
                  result.command          = slcd_pkg::CMD_INCREMENT;
                  result.flag_value       = ~state.increment_on;
               end
               slcd_pkg::CHAR_S: begin
                  state_next.mode      = slcd_pkg::MODE_IDLE;
                  state_next.scroll_on = ~state.scroll_on;
                  result.valid         = 1'b1;
                  result.command       = slcd_pkg::CMD_SCROLL;
                  result.flag_value    = ~state.scroll_on;
               end
               slcd_pkg::CHAR_T: begin
                  state_next.mode    = slcd_pkg::MODE_IDLE;
                  state_next.test_on = ~state.test_on;
                  result.valid       = 1'b1;
                  result.command     = slcd_pkg::CMD_TEST;
                  result.flag_value  = ~state.test_on;
               end
               default: begin
                  // characters past the line limit are dropped
                  if (count < CNT_W'(slcd_pkg::SETTING_MAX)) begin
                     if (count == '0) begin
                        state_next.line_k = (rx_char == slcd_pkg::CHAR_K);
                     end else if (state.line_k && !state.digits_ended) begin
                        if (is_digit) begin
                           state_next.accum = (scaled[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                     : scaled[31:0];
                        end else begin
                           state_next.digits_ended = 1'b1;
                        end
                     end
                     count_next = count_inc;
                  end
               end
            endcase
         end
         slcd_pkg::MODE_TEXT: begin
            if ((rx_char == slcd_pkg::CHAR_LF) || (rx_char == slcd_pkg::CHAR_CR)) begin
               state_next.mode = slcd_pkg::MODE_IDLE;
            end else if (is_print && (count < CNT_W'(TEXT_CAPACITY))) begin
               count_next         = count_inc;
               result.valid       = 1'b1;
               result.command     = slcd_pkg::CMD_APPEND;
               result.text_char   = rx_char[6:0];
               result.text_length = count_inc[4:0];
            end
         end
         default: begin
            // idle, and the unused mode code behaves as idle
            if (rx_char == slcd_pkg::CHAR_SETTING) begin
               state_next.mode         = slcd_pkg::MODE_SETTING;
               state_next.line_k       = 1'b0;
               state_next.digits_ended = 1'b0;
               state_next.accum        = '0;
               count_next              = '0;
            end else if (rx_char == slcd_pkg::CHAR_TEXT) begin
               state_next.mode = slcd_pkg::MODE_TEXT;
               count_next      = '0;
            end else begin
               state_next.mode = slcd_pkg::MODE_IDLE;
            end
         end
      endcase
   end

endmodule
